>>> rtl/tzp_pkg.sv
// ----------------------------------------------------------------------------
// tzp_pkg
// types and constants shared by the tz string parser and its step logic
// ----------------------------------------------------------------------------
`default_nettype none

package tzp_pkg;

    // parse steps that one byte may pass through before it is consumed
    localparam int TZP_STEPS = 6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_M     = 8'h4D;

    localparam logic signed [13:0] RULE_TIME_DEFAULT = 14'sd120;
    localparam logic signed [13:0] DST_SHIFT         = 14'sd60;

    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_TAG_FIRST  = 4'd1,
        PH_TAG_ALPHA  = 4'd2,
        PH_TAG_QUOTED = 4'd3,
        PH_TIME_SIGN  = 4'd4,
        PH_TIME_NUM   = 4'd5,
        PH_TIME_SEP   = 4'd6,
        PH_RULE_COMMA = 4'd7,
        PH_RULE_M     = 4'd8,
        PH_RULE_NUM   = 4'd9,
        PH_RULE_SEP   = 4'd10,
        PH_RULE_SLASH = 4'd11,
        PH_DONE       = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        SEC_STD   = 2'd0,
        SEC_DST   = 2'd1,
        SEC_START = 2'd2,
        SEC_END   = 2'd3
    } section_t;

    typedef struct packed {
        phase_t              phase;
        section_t            section;
        logic [55:0]         tag_buf;
        logic [2:0]          tag_len;
        logic [6:0]          accum;
        logic                digits;
        logic                neg;
        logic [1:0]          tcount;
        logic [6:0]          first;
        logic [6:0]          second;
        logic                failed;
        logic                has_dst;
        logic [55:0]         std_tag;
        logic [55:0]         dst_tag;
        logic signed [13:0]  std_off;
        logic signed [13:0]  dst_off;
        logic signed [13:0]  dst_time;
        logic signed [13:0]  std_time;
        logic [20:0]         dst_when;
        logic [20:0]         std_when;
    } tzp_state_t;

    localparam tzp_state_t TZP_STATE_CLEAR = '0;

endpackage

`default_nettype wire

>>> rtl/tzp_step.sv
// ----------------------------------------------------------------------------
// tzp_step
// one parse step: advances the parser state for one byte, flags consumption
// ----------------------------------------------------------------------------
`default_nettype none

module tzp_step
    import tzp_pkg::*;
#(
    parameter int TAG_CHARS = 7
) (
    input  tzp_state_t  st_i,
    input  logic [7:0]  ch_i,
    input  logic        act_i,
    output tzp_state_t  st_o,
    output logic        act_o,
    output logic        fire_o
);

    localparam logic [2:0] TAG_LIMIT = 3'(TAG_CHARS);

    tzp_state_t         nxt;
    logic               used;
    logic               fire;
    logic               is_dig;
    logic               is_alp;
    logic               is_rule;
    logic [6:0]         acc10;
    logic [6:0]         slot_v;
    logic               slot_present;
    logic               do_end_tag;
    logic               do_end_slot;
    logic               do_end_trip;
    logic [12:0]        mins_u;
    logic signed [13:0] mins;

    assign is_dig  = (ch_i >= 8'h30) && (ch_i <= 8'h39);
    assign is_alp  = ((ch_i >= 8'h41) && (ch_i <= 8'h5A)) ||
                     ((ch_i >= 8'h61) && (ch_i <= 8'h7A));
    assign is_rule = (st_i.phase == PH_RULE_NUM) || (st_i.phase == PH_RULE_SEP);

    // second digit folds into the accumulator, 7 bit wrap
    assign acc10  = 7'({st_i.accum, 3'b000} + {st_i.accum, 1'b0} + {3'b000, ch_i[3:0]});
    assign slot_v = !st_i.digits ? 7'd0 : (is_dig ? acc10 : st_i.accum);

    // h*60 + m
    assign mins_u = 13'({st_i.first, 6'b0} - {st_i.first, 2'b0} + {6'b0, st_i.second});
    assign mins   = st_i.neg ? -$signed({1'b0, mins_u}) : $signed({1'b0, mins_u});

    always_comb begin
        nxt          = st_i;
        used         = 1'b0;
        fire         = 1'b0;
        slot_present = 1'b0;
        do_end_tag   = 1'b0;
        do_end_slot  = 1'b0;
        do_end_trip  = 1'b0;

        if (act_i) begin
            case (st_i.phase)
                PH_START: begin
                    used        = (ch_i == CH_COLON);
                    nxt.section = SEC_STD;
                    nxt.tag_buf = '0;
                    nxt.tag_len = '0;
                    nxt.phase   = PH_TAG_FIRST;
                end
                PH_TAG_FIRST: begin
                    if (ch_i == CH_LT) begin
                        nxt.phase = PH_TAG_QUOTED;
                        used      = 1'b1;
                    end else if (is_alp) begin
                        nxt.phase = PH_TAG_ALPHA;
                    end else begin
                        do_end_tag = 1'b1;
                    end
                end
                PH_TAG_ALPHA, PH_TAG_QUOTED: begin
                    if (st_i.phase == PH_TAG_QUOTED && ch_i == CH_GT) begin
                        do_end_tag = 1'b1;
                        used       = 1'b1;
                    end else if ((st_i.phase == PH_TAG_QUOTED) ? (ch_i == CH_NUL) : !is_alp) begin
                        do_end_tag = 1'b1;
                    end else begin
                        if (st_i.tag_len < TAG_LIMIT) begin
                            nxt.tag_buf[{st_i.tag_len, 3'b000} +: 8] = ch_i;
                            nxt.tag_len = st_i.tag_len + 3'd1;
                        end
                        used = 1'b1;
                    end
                end
                PH_TIME_SIGN: begin
                    if (ch_i == CH_MINUS) begin
                        nxt.neg = 1'b1;
                        used    = 1'b1;
                    end else if (ch_i == CH_PLUS) begin
                        used = 1'b1;
                    end
                    nxt.first  = '0;
                    nxt.second = '0;
                    nxt.accum  = '0;
                    nxt.digits = 1'b0;
                    nxt.tcount = '0;
                    nxt.phase  = PH_TIME_NUM;
                end
                PH_TIME_NUM, PH_RULE_NUM: begin
                    if (!st_i.digits) begin
                        if (is_dig) begin
                            nxt.accum  = {3'b000, ch_i[3:0]};
                            nxt.digits = 1'b1;
                            used       = 1'b1;
                        end else begin
                            do_end_slot = 1'b1;
                        end
                    end else begin
                        do_end_slot  = 1'b1;
                        slot_present = 1'b1;
                        used         = is_dig;
                    end
                end
                PH_TIME_SEP, PH_RULE_SEP: begin
                    if (ch_i == (is_rule ? CH_DOT : CH_COLON)) begin
                        nxt.digits = 1'b0;
                        nxt.accum  = '0;
                        nxt.phase  = is_rule ? PH_RULE_NUM : PH_TIME_NUM;
                        used       = 1'b1;
                    end else begin
                        do_end_trip = 1'b1;
                    end
                end
                PH_RULE_COMMA: begin
                    if (ch_i == CH_COMMA) begin
                        nxt.phase = PH_RULE_M;
                        used      = 1'b1;
                    end else begin
                        nxt.failed = 1'b1;
                        nxt.phase  = PH_DONE;
                    end
                end
                PH_RULE_M: begin
                    if (ch_i == CH_M) begin
                        nxt.first  = '0;
                        nxt.second = '0;
                        nxt.accum  = '0;
                        nxt.digits = 1'b0;
                        nxt.tcount = '0;
                        nxt.phase  = PH_RULE_NUM;
                        used       = 1'b1;
                    end else begin
                        nxt.failed = 1'b1;
                        nxt.phase  = PH_DONE;
                    end
                end
                PH_RULE_SLASH: begin
                    if (ch_i == CH_SLASH) begin
                        nxt.neg   = 1'b0;
                        nxt.phase = PH_TIME_SIGN;
                        used      = 1'b1;
                    end else if (st_i.section == SEC_START) begin
                        nxt.dst_time = RULE_TIME_DEFAULT;
                        nxt.section  = SEC_END;
                        nxt.phase    = PH_RULE_COMMA;
                    end else begin
                        nxt.std_time = RULE_TIME_DEFAULT;
                        nxt.phase    = PH_DONE;
                    end
                end
                PH_DONE: begin
                    used = 1'b1;
                    fire = (ch_i == CH_NUL);
                end
                default: begin
                    used = 1'b1;
                    fire = (ch_i == CH_NUL);
                end
            endcase

            // tag finished
            if (do_end_tag) begin
                if (st_i.section == SEC_STD) begin
                    if (st_i.tag_len == 3'd0) begin
                        nxt.failed = 1'b1;
                        nxt.phase  = PH_DONE;
                    end else begin
                        nxt.std_tag = st_i.tag_buf;
                        nxt.neg     = 1'b0;
                        nxt.phase   = PH_TIME_SIGN;
                    end
                end else if (st_i.tag_len == 3'd0) begin
                    // empty daylight tag: no dst
                    nxt.dst_tag = st_i.std_tag;
                    nxt.dst_off = st_i.std_off;
                    nxt.has_dst = 1'b0;
                    nxt.phase   = PH_DONE;
                end else begin
                    nxt.dst_tag = st_i.tag_buf;
                    nxt.has_dst = 1'b1;
                    nxt.section = SEC_DST;
                    nxt.neg     = 1'b0;
                    nxt.phase   = PH_TIME_SIGN;
                end
            end

            // number slot finished
            if (do_end_slot) begin
                if (st_i.tcount == 2'd0 && !slot_present) begin
                    do_end_trip = 1'b1;
                end else begin
                    case (st_i.tcount)
                        2'd0:    nxt.first  = slot_v;
                        2'd1:    nxt.second = slot_v;
                        default: nxt.accum  = slot_v;
                    endcase
                    nxt.tcount = st_i.tcount + 2'd1;
                    if (st_i.tcount == 2'd2) begin
                        do_end_trip = 1'b1;
                    end else begin
                        nxt.phase = is_rule ? PH_RULE_SEP : PH_TIME_SEP;
                    end
                end
            end

            // triplet finished
            if (do_end_trip) begin
                if (is_rule) begin
                    if (nxt.tcount != 2'd3 || st_i.first == 7'd0 || st_i.second == 7'd0) begin
                        nxt.failed = 1'b1;
                        nxt.phase  = PH_DONE;
                    end else begin
                        if (st_i.section == SEC_START) begin
                            nxt.dst_when = {7'(st_i.first - 7'd1), 7'(st_i.second - 7'd1),
                                            nxt.accum};
                        end else begin
                            nxt.std_when = {7'(st_i.first - 7'd1), 7'(st_i.second - 7'd1),
                                            nxt.accum};
                        end
                        nxt.phase = PH_RULE_SLASH;
                    end
                end else if (nxt.tcount == 2'd0) begin
                    // missing dst offset takes the default
                    if (st_i.section == SEC_DST) begin
                        nxt.dst_off = st_i.std_off + DST_SHIFT;
                        nxt.section = SEC_START;
                        nxt.phase   = PH_RULE_COMMA;
                    end else begin
                        nxt.failed = 1'b1;
                        nxt.phase  = PH_DONE;
                    end
                end else begin
                    case (st_i.section)
                        SEC_STD: begin
                            nxt.std_off = -mins;
                            nxt.section = SEC_DST;
                            nxt.tag_buf = '0;
                            nxt.tag_len = '0;
                            nxt.phase   = PH_TAG_FIRST;
                        end
                        SEC_DST: begin
                            nxt.dst_off = -mins;
                            nxt.section = SEC_START;
                            nxt.phase   = PH_RULE_COMMA;
                        end
                        SEC_START: begin
                            nxt.dst_time = mins;
                            nxt.section  = SEC_END;
                            nxt.phase    = PH_RULE_COMMA;
                        end
                        default: begin
                            nxt.std_time = mins;
                            nxt.phase    = PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    assign st_o   = nxt;
    assign act_o  = act_i && !used;
    assign fire_o = fire;

endmodule

`default_nettype wire

>>> rtl/posix_tz_string_parser_unit.sv
// ----------------------------------------------------------------------------
// posix_tz_string_parser_unit
// parses a posix tz string one byte per item, one result per nul byte
// ----------------------------------------------------------------------------
// result path: the accepted nul byte sits in the input register, and the parse
// steps feed the result register from it
// throughput: one byte per cycle; a byte stalls only while a finished result
// waits and the held byte would produce another one
// reset: aresetn low clears parser state and both valid flags, next string
// starts fresh
`default_nettype none

module posix_tz_string_parser_unit
    import tzp_pkg::*;
#(
    parameter int TAG_CHARS = 7
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] ch
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [215:0] m_tdata    // ok, has_dst, std_tag, std_offset, dst_tag,
                                         // dst_offset, dst_when, dst_time, std_when,
                                         // std_time, zero pad
);

    // input register
    logic [7:0]   ch_reg;
    logic         ch_vld_reg;

    // parser state, advanced once per processed byte
    tzp_state_t   st_reg;
    tzp_state_t   st_next;

    // result register
    logic         m_tvalid_reg;
    logic [215:0] m_tdata_reg;
    logic [215:0] m_tdata_next;

    // chain of parse steps: a byte that is not consumed moves on to the next
    tzp_state_t   chain_st  [0:TZP_STEPS];
    logic         chain_act [0:TZP_STEPS];
    logic [TZP_STEPS-1:0] chain_fire;

    logic         fire;
    logic         out_free;
    logic         proc;
    logic         ok;
    tzp_state_t   fin;

    assign chain_st[0]  = st_reg;
    assign chain_act[0] = 1'b1;

    for (genvar i = 0; i < TZP_STEPS; i++) begin : g_step
        tzp_step #(
            .TAG_CHARS (TAG_CHARS)
        ) u_step (
            .st_i   (chain_st[i]),
            .ch_i   (ch_reg),
            .act_i  (chain_act[i]),
            .st_o   (chain_st[i+1]),
            .act_o  (chain_act[i+1]),
            .fire_o (chain_fire[i])
        );
    end

    // a nul byte reaching the done phase emits the result
    assign fire = |chain_fire;
    assign fin  = chain_st[TZP_STEPS];

    // after a result the parser starts over on the next string
    assign st_next = fire ? TZP_STATE_CLEAR : fin;

    // held byte is processed unless it would emit into a full result register
    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = ch_vld_reg && (out_free || !fire);
    assign s_tready = !ch_vld_reg || proc;

    // failed strings report all zeros
    assign ok = !fin.failed;

    always_comb begin
        m_tdata_next = '0;
        if (ok) begin
            m_tdata_next[0]       = 1'b1;
            m_tdata_next[1]       = fin.has_dst;
            m_tdata_next[57:2]    = fin.std_tag;
            m_tdata_next[71:58]   = fin.std_off;
            m_tdata_next[127:72]  = fin.dst_tag;
            m_tdata_next[141:128] = fin.dst_off;
            m_tdata_next[162:142] = fin.dst_when;
            m_tdata_next[176:163] = fin.dst_time;
            m_tdata_next[197:177] = fin.std_when;
            m_tdata_next[211:198] = fin.std_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_vld_reg   <= 1'b0;
            st_reg       <= TZP_STATE_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                ch_vld_reg <= s_tvalid;
            end
            if (proc) begin
                st_reg <= st_next;
            end
            if (proc && fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg <= s_tdata;
        end
        if (proc && fire) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

>>> tb/tb_posix_tz_string_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_posix_tz_string_parser_unit
// streams posix tz strings into the parser one byte per item and checks every
// decoded zone against a cycle-free model of the grammar kept in this bench
// ----------------------------------------------------------------------------
module tb_posix_tz_string_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tzp_pkg::*;

    localparam int TAG_KEEP       = 7;     // tag bytes kept by the parser
    localparam int IDLE_PCT       = 11;    // chance per cycle that a side idles
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving at all
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the bench has drained
    localparam int QUIET_ITEMS    = 300;   // random bytes sent with no idling
    localparam int NOISY_ITEMS    = 700;   // random bytes sent with idling

    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_QUERY   = 8'h3F;

    // one decoded zone, the fields of one result item
    typedef struct {
        bit          ok;
        bit          has_dst;
        logic [55:0] std_tag;
        logic [13:0] std_off;
        logic [55:0] dst_tag;
        logic [13:0] dst_off;
        logic [20:0] dst_when;
        logic [13:0] dst_time;
        logic [20:0] std_when;
        logic [13:0] std_time;
    } tz_zone_t;

    // dut ports, all inputs known from time zero
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;  // [7:0] ch
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;           // ok, has_dst, std_tag, std_offset, dst_tag,
                                     // dst_offset, dst_when, dst_time, std_when,
                                     // std_time, zero pad

    // bench control shared between the processes
    bit gaps_on  = 1'b0;   // random idling on both sides
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off
    int errors       = 0;
    int sent_items   = 0;
    int stall_cycles = 0;

    tz_zone_t   expected_zones[$];   // decoded zones still owed by the dut
    logic [7:0] zone_text[$];        // bytes of the string being built

    // parser state of the bench's own grammar model
    phase_t      p_phase;
    section_t    p_sec;
    logic [55:0] p_tag;
    int          p_tag_len;
    logic [6:0]  p_accum;
    bit          p_digit;
    bit          p_neg;
    int          p_slots;
    logic [6:0]  p_first;
    logic [6:0]  p_second;
    bit          p_failed;
    tz_zone_t    p_zone;

    posix_tz_string_parser_unit #(
        .TAG_CHARS (TAG_KEEP)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // grammar model
    // ------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    // back to the start of a fresh string
    function automatic void clear_parse();
        p_phase   = PH_START;
        p_sec     = SEC_STD;
        p_tag     = '0;
        p_tag_len = 0;
        p_accum   = '0;
        p_digit   = 1'b0;
        p_neg     = 1'b0;
        p_slots   = 0;
        p_first   = '0;
        p_second  = '0;
        p_failed  = 1'b0;
        p_zone    = '{default: '0};
    endfunction

    function automatic void parse_fail();
        p_failed = 1'b1;
        p_phase  = PH_DONE;
    endfunction

    function automatic void open_tag(section_t s);
        p_sec     = s;
        p_tag     = '0;
        p_tag_len = 0;
        p_phase   = PH_TAG_FIRST;
    endfunction

    function automatic void open_time(section_t s);
        p_sec   = s;
        p_neg   = 1'b0;
        p_phase = PH_TIME_SIGN;
    endfunction

    function automatic void open_triplet(phase_t ph);
        p_first  = '0;
        p_second = '0;
        p_accum  = '0;
        p_digit  = 1'b0;
        p_slots  = 0;
        p_phase  = ph;
    endfunction

    function automatic void open_rule(section_t s);
        p_sec   = s;
        p_phase = PH_RULE_COMMA;
    endfunction

    function automatic void close_tag();
        if (p_sec == SEC_STD) begin
            // a standard tag must hold at least one byte
            if (p_tag_len == 0) begin
                parse_fail();
            end else begin
                p_zone.std_tag = p_tag;
                open_time(SEC_STD);
            end
        end else if (p_tag_len == 0) begin
            // no daylight tag: daylight copies the standard values
            p_zone.dst_tag = p_zone.std_tag;
            p_zone.dst_off = p_zone.std_off;
            p_zone.has_dst = 1'b0;
            p_phase        = PH_DONE;
        end else begin
            p_zone.dst_tag = p_tag;
            p_zone.has_dst = 1'b1;
            open_time(SEC_DST);
        end
    endfunction

    function automatic void close_time();
        int mins;
        if (p_slots == 0) begin
            // only the daylight offset may be missing, it then defaults
            if (p_sec == SEC_DST) begin
                p_zone.dst_off = p_zone.std_off + DST_SHIFT;
                open_rule(SEC_START);
            end else begin
                parse_fail();
            end
        end else begin
            mins = int'(p_first) * 60 + int'(p_second);
            if (p_neg) mins = -mins;
            case (p_sec)
                SEC_STD: begin
                    p_zone.std_off = 14'(-mins);
                    open_tag(SEC_DST);
                end
                SEC_DST: begin
                    p_zone.dst_off = 14'(-mins);
                    open_rule(SEC_START);
                end
                SEC_START: begin
                    p_zone.dst_time = 14'(mins);
                    open_rule(SEC_END);
                end
                default: begin
                    p_zone.std_time = 14'(mins);
                    p_phase         = PH_DONE;
                end
            endcase
        end
    endfunction

    function automatic void close_rule();
        logic [20:0] when;
        if (p_slots != 3 || p_first == 0 || p_second == 0) begin
            parse_fail();
        end else begin
            when = {7'(p_first - 7'd1), 7'(p_second - 7'd1), p_accum};
            if (p_sec == SEC_START) p_zone.dst_when = when;
            else p_zone.std_when = when;
            p_phase = PH_RULE_SLASH;
        end
    endfunction

    function automatic void close_triplet(bit rule);
        if (rule) close_rule();
        else close_time();
    endfunction

    // one number slot of h:m:s or m.w.d is complete
    function automatic void close_slot(bit present, bit rule);
        logic [6:0] v;
        v = present ? p_accum : 7'd0;
        if (p_slots == 0 && !present) begin
            close_triplet(rule);
        end else begin
            case (p_slots)
                0:       p_first  = v;
                1:       p_second = v;
                default: p_accum  = v;
            endcase
            p_slots++;
            if (p_slots >= 3) close_triplet(rule);
            else if (rule) p_phase = PH_RULE_SEP;
            else p_phase = PH_TIME_SEP;
        end
    endfunction

    // returns 1 when the byte is consumed by the number
    function automatic bit take_number(logic [7:0] c, bit rule);
        if (!p_digit) begin
            if (is_digit(c)) begin
                p_accum = 7'(c - CH_ZERO);
                p_digit = 1'b1;
                return 1'b1;
            end
            close_slot(1'b0, rule);
            return 1'b0;
        end
        // second digit closes the number, a third one is a new token
        if (is_digit(c)) begin
            p_accum = 7'(p_accum * 10 + (c - CH_ZERO));
            close_slot(1'b1, rule);
            return 1'b1;
        end
        close_slot(1'b1, rule);
        return 1'b0;
    endfunction

    function automatic bit take_separator(logic [7:0] c, bit rule);
        if (c == (rule ? CH_DOT : CH_COLON)) begin
            p_digit = 1'b0;
            p_accum = '0;
            if (rule) p_phase = PH_RULE_NUM;
            else p_phase = PH_TIME_NUM;
            return 1'b1;
        end
        close_triplet(rule);
        return 1'b0;
    endfunction

    // feed one accepted byte; a nul at the decision point owes one zone
    function automatic void parse_char(logic [7:0] c);
        bit       used;
        int       guard;
        tz_zone_t z;
        used  = 1'b0;
        guard = 0;
        while (!used && guard < 64) begin
            guard++;
            case (p_phase)
                PH_START: begin
                    used = (c == CH_COLON);
                    open_tag(SEC_STD);
                end
                PH_TAG_FIRST: begin
                    if (c == CH_LT) begin
                        p_phase = PH_TAG_QUOTED;
                        used    = 1'b1;
                    end else if (is_alpha(c)) begin
                        p_phase = PH_TAG_ALPHA;
                    end else begin
                        close_tag();
                    end
                end
                PH_TAG_ALPHA, PH_TAG_QUOTED: begin
                    if (p_phase == PH_TAG_QUOTED && c == CH_GT) begin
                        close_tag();
                        used = 1'b1;
                    end else if (p_phase == PH_TAG_QUOTED ? (c == CH_NUL) : !is_alpha(c)) begin
                        // an unterminated quote ends at nul, which is parsed again
                        close_tag();
                    end else begin
                        if (p_tag_len < TAG_KEEP) begin
                            p_tag[8*p_tag_len +: 8] = c;
                            p_tag_len++;
                        end
                        used = 1'b1;
                    end
                end
                PH_TIME_SIGN: begin
                    if (c == CH_MINUS) begin
                        p_neg = 1'b1;
                        used  = 1'b1;
                    end else if (c == CH_PLUS) begin
                        used = 1'b1;
                    end
                    open_triplet(PH_TIME_NUM);
                end
                PH_TIME_NUM: used = take_number(c, 1'b0);
                PH_TIME_SEP: used = take_separator(c, 1'b0);
                PH_RULE_COMMA: begin
                    if (c == CH_COMMA) begin
                        p_phase = PH_RULE_M;
                        used    = 1'b1;
                    end else begin
                        parse_fail();
                    end
                end
                PH_RULE_M: begin
                    if (c == CH_M) begin
                        open_triplet(PH_RULE_NUM);
                        used = 1'b1;
                    end else begin
                        parse_fail();
                    end
                end
                PH_RULE_NUM: used = take_number(c, 1'b1);
                PH_RULE_SEP: used = take_separator(c, 1'b1);
                PH_RULE_SLASH: begin
                    if (c == CH_SLASH) begin
                        open_time(p_sec);
                        used = 1'b1;
                    end else if (p_sec == SEC_START) begin
                        p_zone.dst_time = RULE_TIME_DEFAULT;
                        open_rule(SEC_END);
                    end else begin
                        p_zone.std_time = RULE_TIME_DEFAULT;
                        p_phase         = PH_DONE;
                    end
                end
                default: begin
                    // verdict is in, everything up to nul is ignored
                    used = 1'b1;
                    if (c == CH_NUL) begin
                        z = '{default: '0};
                        if (!p_failed) begin
                            z    = p_zone;
                            z.ok = 1'b1;
                        end
                        expected_zones.push_back(z);
                        clear_parse();
                    end
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string name, logic [55:0] want, logic [55:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            errors++;
        end
    endfunction

    // sample both channels at the rising edge; results are checked first,
    // then the accepted byte advances the model
    always @(posedge aclk) begin : monitor
        tz_zone_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_zones.size() == 0) begin
                    $error("result item with no zone expected");
                    errors++;
                end else begin
                    want = expected_zones.pop_front();
                    compare_field("ok",         want.ok,       m_tdata[0]);
                    compare_field("has_dst",    want.has_dst,  m_tdata[1]);
                    compare_field("std_tag",    want.std_tag,  m_tdata[57:2]);
                    compare_field("std_offset", want.std_off,  m_tdata[71:58]);
                    compare_field("dst_tag",    want.dst_tag,  m_tdata[127:72]);
                    compare_field("dst_offset", want.dst_off,  m_tdata[141:128]);
                    compare_field("dst_when",   want.dst_when, m_tdata[162:142]);
                    compare_field("dst_time",   want.dst_time, m_tdata[176:163]);
                    compare_field("std_when",   want.std_when, m_tdata[197:177]);
                    compare_field("std_time",   want.std_time, m_tdata[211:198]);
                    compare_field("pad",        56'd0,         m_tdata[215:212]);
                end
            end
            if (s_tvalid && s_tready) parse_char(s_tdata);
        end
    end

    // watchdog: too long with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one byte from a falling edge and hold it until accepted
    task automatic send_char(logic [7:0] c);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // send the built string followed by its nul
    task automatic send_zone();
        int i;
        for (i = 0; i < zone_text.size(); i++) send_char(zone_text[i]);
        send_char(CH_NUL);
        sent_items += zone_text.size() + 1;
        zone_text.delete();
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) zone_text.push_back(s[i]);
        send_zone();
    endtask

    // sender pause until every owed zone has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_zones.size() != 0);
    endtask

    // a number of one or two digits, two forced when it needs them
    function automatic void add_num(int v);
        if (v >= 10 || $urandom_range(3) == 0) zone_text.push_back(8'(CH_ZERO + v / 10));
        zone_text.push_back(8'(CH_ZERO + v % 10));
    endfunction

    function automatic void add_tag(bit allow_empty);
        int         len;
        int         i;
        logic [7:0] c;
        if ($urandom_range(3) == 0) begin
            // quoted tag, any byte but nul and the closing bracket
            len = allow_empty && $urandom_range(15) == 0 ? 0 : $urandom_range(9, 1);
            zone_text.push_back(CH_LT);
            for (i = 0; i < len; i++) begin
                c = 8'($urandom_range(255, 1));
                if (c == CH_GT) c = CH_QUERY;
                zone_text.push_back(c);
            end
            if ($urandom_range(9) != 0) zone_text.push_back(CH_GT);
        end else begin
            len = allow_empty && $urandom_range(15) == 0 ? 0 : $urandom_range(9, 1);
            for (i = 0; i < len; i++) begin
                zone_text.push_back(8'(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A)
                                       + $urandom_range(25)));
            end
        end
    endfunction

    // h[:m[:s]] with an optional sign, mostly realistic hours
    function automatic void add_time();
        case ($urandom_range(2))
            0: zone_text.push_back(CH_MINUS);
            1: zone_text.push_back(CH_PLUS);
            default: ;
        endcase
        add_num($urandom_range(3) == 0 ? $urandom_range(99) : $urandom_range(24));
        if ($urandom_range(19) == 0) add_num($urandom_range(9));  // a stray third digit
        if ($urandom_range(1)) begin
            zone_text.push_back(CH_COLON);
            if ($urandom_range(15) != 0) add_num($urandom_range(99));
            if ($urandom_range(2) == 0) begin
                zone_text.push_back(CH_COLON);
                add_num($urandom_range(99));
            end
        end
    endfunction

    function automatic void add_rule();
        zone_text.push_back(CH_COMMA);
        zone_text.push_back(CH_M);
        add_num($urandom_range(9) == 0 ? $urandom_range(99) : $urandom_range(12, 1));
        zone_text.push_back(CH_DOT);
        add_num($urandom_range(9) == 0 ? $urandom_range(99) : $urandom_range(5, 1));
        zone_text.push_back(CH_DOT);
        if ($urandom_range(19) != 0) begin
            add_num($urandom_range(9) == 0 ? $urandom_range(99) : $urandom_range(6));
        end
        if ($urandom_range(1)) begin
            zone_text.push_back(CH_SLASH);
            add_time();
        end
    endfunction

    // mostly well-formed zones with random content, some broken, some noise
    function automatic void build_zone();
        int pos;
        int i;
        zone_text.delete();
        if ($urandom_range(99) < 15) begin
            for (i = $urandom_range(12); i > 0; i--) zone_text.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(9) < 3) zone_text.push_back(CH_COLON);
            add_tag(1'b1);
            add_time();
            if ($urandom_range(3) != 0) begin
                add_tag(1'b1);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: add_time();
                    5:             zone_text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
                    default: ;
                endcase
                add_rule();
                add_rule();
            end
            if ($urandom_range(9) == 0 && zone_text.size() > 0) begin
                pos = $urandom_range(zone_text.size() - 1);
                if ($urandom_range(1)) zone_text[pos] = 8'($urandom_range(255, 1));
                else while (zone_text.size() > pos) void'(zone_text.pop_back());
            end
            if ($urandom_range(99) < 15) begin
                for (i = $urandom_range(5, 1); i > 0; i--) begin
                    zone_text.push_back(8'($urandom_range(255, 1)));
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // full zones with both rules, extreme offsets and high tag bytes
    task automatic test_full_zones();
        send_text("EST5EDT,M3.2.0,M11.1.0");
        send_text(":<\200\377>-99:99<X>+99:99:99,M12.5.6/-1:5,M1.1.0/23");
    endtask

    // each corner of the grammar once
    task automatic test_corner_cases();
        send_text("<>5");                    // empty standard tag fails
        send_text("UTC0 trail");             // no daylight tag, trailing bytes ignored
        send_text("<ABCDEFGHIJ");            // truncated tag, unterminated quote
        send_text("A123");                   // third digit is a new token
        send_text("A1:");                    // missing minutes count as zero
        send_text("A1B-,M9.99.9,M99.9.");    // bare sign, wide rules, missing weekday
        send_text("A1B,M0.1.0,M1.1.0");      // month zero fails
        send_text("A1B,M1.0.0,M1.1.0");      // week zero fails
    endtask

    task automatic test_random_zones(int n_items);
        int start;
        start = sent_items;
        while (sent_items - start < n_items) begin
            build_zone();
            send_zone();
            if ($urandom_range(15) == 0) wait_drained();
        end
    endtask

    // receiver holds off long enough that the parser stalls its input
    task automatic test_backpressure();
        int i;
        hold_req = 1'b1;
        for (i = 0; i < 4; i++) begin
            build_zone();
            send_zone();
        end
        wait_drained();
    endtask

    initial begin
        clear_parse();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_full_zones();
        test_corner_cases();
        wait_drained();

        // a long stretch with no idling on either side
        gaps_on = 1'b0;
        test_random_zones(QUIET_ITEMS);

        gaps_on = 1'b1;
        test_backpressure();
        test_random_zones(NOISY_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_zones.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/tzp_pkg.sv
rtl/tzp_step.sv
rtl/posix_tz_string_parser_unit.sv
tb/tb_posix_tz_string_parser_unit.sv
